@@ sv/tac_pkg.sv @@
// ----------------------------------------------------------------------------
// tac_pkg
// shared constants, types and register indexes of the trigger conditioner
// ----------------------------------------------------------------------------
`default_nettype none

package tac_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int ALPHA_W     = 9;
    localparam int FRAC_BITS   = 8;
    localparam int LEVEL_W     = 8;
    localparam int QUOT_BITS   = LEVEL_W;
    localparam int NUM_W       = SAMPLE_BITS + QUOT_BITS;
    localparam int SPAN_W      = SAMPLE_BITS + 1;
    localparam int PROD_W      = ALPHA_W + 1 + SAMPLE_BITS + 1;
    localparam int CNT_W       = $clog2(QUOT_BITS + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = (SAMPLE_BITS > ALPHA_W) ? SAMPLE_BITS : ALPHA_W;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_LEVEL  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_MINIMUM = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_MAXIMUM = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SPAN    = CFG_IDX_W'(4);

    // reset values
    localparam logic [ALPHA_W-1:0]     RST_ALPHA    = ALPHA_W'(128);
    localparam logic [LEVEL_W-1:0]     RST_DEADZONE = LEVEL_W'(13);
    localparam logic [SAMPLE_BITS-1:0] RST_MINIMUM  = SAMPLE_BITS'(975);
    localparam logic [SAMPLE_BITS-1:0] RST_MAXIMUM  = SAMPLE_BITS'(2375);
    localparam logic [SAMPLE_BITS-1:0] RST_SPAN     = SAMPLE_BITS'(1000);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILTER,
        ST_SCALE,
        ST_CHECK,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                   start;
        logic [NUM_W-1:0]       numer;
        logic [SAMPLE_BITS-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [QUOT_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ sv/tac_div.sv @@
// ----------------------------------------------------------------------------
// tac_div
// restoring divider, one quotient bit per cycle; the numerator is known to
// be below denom*2^QUOT_BITS, so the quotient fits in QUOT_BITS bits
// ----------------------------------------------------------------------------
`default_nettype none

module tac_div
    import tac_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [SAMPLE_BITS-1:0] rem_reg;
    logic [SAMPLE_BITS-1:0] den_reg;
    logic [QUOT_BITS-1:0]   low_reg;
    logic [QUOT_BITS-1:0]   quot_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   done_reg;

    logic [SAMPLE_BITS:0]   trial;
    logic [SAMPLE_BITS:0]   diff;
    logic                   fits;

    // one shared compare and subtract
    assign trial = {rem_reg, low_reg[QUOT_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                cnt_reg <= CNT_W'(QUOT_BITS);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.numer[NUM_W-1:QUOT_BITS];
            low_reg <= req.numer[QUOT_BITS-1:0];
            den_reg <= req.denom;
        end else if (cnt_reg != '0) begin
            rem_reg  <= fits ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
            low_reg  <= {low_reg[QUOT_BITS-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_BITS-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

`default_nettype wire

@@ sv/trigger_autorange_conditioner_core.sv @@
// ----------------------------------------------------------------------------
// trigger_autorange_conditioner_core
// min/max auto-ranging, first-order low-pass and 0..255 scaling of one
// analog trigger channel
// ----------------------------------------------------------------------------
// usage
//   input channel  s_valid/s_ready/s_sample: one raw converter reading per
//     transfer; s_ready is high only while the sequencer is idle
//   result channel m_valid/m_ready/m_level/m_smoothed/m_range_changed: one
//     result per input transfer, held in an output register
//   config channel cfg_valid/cfg_ready/cfg_index/cfg_data: always ready;
//     writes to the calibration registers also load the running min, max
//     or span at once; indexes beyond the list are ignored
// sequence
//   filter, scale, saturation check, divide, finish from acceptance to the
//   result register on the divide path; the divide is skipped when the
//   quotient saturates, the check and divide when the span or minimum rule
//   forces the level; a new sample is taken only after the finish step
// reset
//   aresetn synchronous, active low: registers to their reset values, the
//   smoothed value to zero, min/max/span to the calibration defaults
// stalls
//   a waiting result does not block the next sample; a finished item waits
//   in the finish step until the output register is free
// ----------------------------------------------------------------------------
`default_nettype none

module trigger_autorange_conditioner_core
    import tac_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [SAMPLE_BITS-1:0] s_sample,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [LEVEL_W-1:0]          m_level,
    output logic [SAMPLE_BITS-1:0]      m_smoothed,
    output logic                        m_range_changed,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [ALPHA_W-1:0]     alpha_reg;
    logic [LEVEL_W-1:0]     deadzone_reg;

    // running state
    logic [SAMPLE_BITS-1:0]   filt_reg;
    logic [SAMPLE_BITS-1:0]   min_reg;
    logic [SAMPLE_BITS-1:0]   max_reg;
    logic signed [SPAN_W-1:0] span_reg;

    // per-item working registers
    state_t                 state_reg, state_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   changed_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [LEVEL_W-1:0]     lvl_reg;

    // output register
    logic                   m_valid_reg;
    logic [LEVEL_W-1:0]     m_level_reg;
    logic [SAMPLE_BITS-1:0] m_smoothed_reg;
    logic                   m_changed_reg;

    // sequencer strobes
    logic accept;
    logic do_filter;
    logic do_scale;
    logic do_check;
    logic do_finish;
    logic cfg_write;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // ---------------------------------------------------------------- filter
    logic [ALPHA_W-1:0]       alpha_sat;
    logic signed [PROD_W-1:0] alpha_ext;
    logic signed [PROD_W-1:0] step_ext;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] acc;
    logic [SAMPLE_BITS-1:0]   filt_next;

    // alpha above one saturates so the output follows the sample
    assign alpha_sat = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign alpha_ext = $signed({{(PROD_W-ALPHA_W){1'b0}}, alpha_sat});
    // sample minus previous output, sign-extended
    assign step_ext  = PROD_W'($signed({1'b0, sample_reg}) - $signed({1'b0, filt_reg}));

    // a*s + (1-a)*f rewritten as f*one + a*(s - f): a single multiplier
    assign prod      = alpha_ext * step_ext;
    assign acc       = prod + $signed({{(PROD_W-SAMPLE_BITS-FRAC_BITS){1'b0}},
                                       filt_reg, {FRAC_BITS{1'b0}}});
    assign filt_next = acc[SAMPLE_BITS+FRAC_BITS-1:FRAC_BITS];

    // --------------------------------------------------------- range update
    logic                     below_min;
    logic                     above_max;
    logic [SAMPLE_BITS-1:0]   min_next;
    logic [SAMPLE_BITS-1:0]   max_next;
    logic signed [SPAN_W-1:0] span_next;

    // compared against the minimum first, then the maximum
    assign below_min = sample_reg < min_reg;
    assign above_max = !below_min && (sample_reg > max_reg);
    assign min_next  = below_min ? sample_reg : min_reg;
    assign max_next  = above_max ? sample_reg : max_reg;
    assign span_next = $signed({1'b0, max_next}) - $signed({1'b0, min_next});

    // --------------------------------------------------------------- scaling
    logic signed [SPAN_W-1:0] lvl_diff;
    logic [SAMPLE_BITS-1:0]   diff_mag;
    logic                     span_nonpos;
    logic                     diff_pos;
    logic [NUM_W-1:0]         num_next;
    logic [NUM_W-1:0]         sat_bound;
    logic                     sat_hit;
    logic [LEVEL_W-1:0]       lvl_final;

    assign lvl_diff    = $signed({1'b0, filt_reg}) - $signed({1'b0, min_reg});
    assign diff_mag    = lvl_diff[SAMPLE_BITS-1:0];
    assign diff_pos    = !lvl_diff[SPAN_W-1] && (lvl_diff != '0);
    assign span_nonpos = span_reg[SPAN_W-1] || (span_reg == '0);
    // diff * 255 as diff * 256 - diff
    assign num_next    = {diff_mag, {QUOT_BITS{1'b0}}} - {{QUOT_BITS{1'b0}}, diff_mag};
    // quotient above the level range saturates; also keeps the divider in range
    assign sat_bound   = {span_reg[SAMPLE_BITS-1:0], {QUOT_BITS{1'b0}}};
    assign sat_hit     = num_reg >= sat_bound;
    // deadzone on the way out
    assign lvl_final   = (lvl_reg < deadzone_reg) ? '0 : lvl_reg;

    assign div_req.start = do_check && !sat_hit;
    assign div_req.numer = num_reg;
    assign div_req.denom = span_reg[SAMPLE_BITS-1:0];

    tac_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ------------------------------------------------------------- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        do_filter  = 1'b0;
        do_scale   = 1'b0;
        do_check   = 1'b0;
        do_finish  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_FILTER;
                end
            end
            ST_FILTER: begin
                do_filter  = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                do_scale = 1'b1;
                // forced levels skip the divider
                if (span_nonpos || !diff_pos) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                do_check = 1'b1;
                if (sat_hit) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_rsp.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait for the output register to be free
                if (!m_valid_reg || m_ready) begin
                    do_finish  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // ------------------------------------------- config and running state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg     <= RST_ALPHA;
            deadzone_reg  <= RST_DEADZONE;
            filt_reg      <= '0;
            min_reg       <= RST_MINIMUM;
            max_reg       <= RST_MAXIMUM;
            span_reg      <= $signed({1'b0, RST_SPAN});
        end else begin
            if (do_filter) begin
                filt_reg <= filt_next;
                min_reg  <= min_next;
                max_reg  <= max_next;
                if (below_min || above_max) begin
                    span_reg <= span_next;
                end
            end
            // calibration writes load the running bounds as well
            if (cfg_write) begin
                case (cfg_index)
                    REG_FILTER_ALPHA: begin
                        alpha_reg <= cfg_data[ALPHA_W-1:0];
                    end
                    REG_DEADZONE_LEVEL: begin
                        deadzone_reg <= cfg_data[LEVEL_W-1:0];
                    end
                    REG_INITIAL_MINIMUM: begin
                        min_reg      <= cfg_data[SAMPLE_BITS-1:0];
                    end
                    REG_INITIAL_MAXIMUM: begin
                        max_reg      <= cfg_data[SAMPLE_BITS-1:0];
                    end
                    REG_INITIAL_SPAN: begin
                        span_reg      <= $signed({1'b0, cfg_data[SAMPLE_BITS-1:0]});
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------ working payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample;
        end
        if (do_filter) begin
            changed_reg <= below_min || above_max;
        end
        if (do_scale) begin
            num_reg <= num_next;
            if (span_nonpos) begin
                lvl_reg <= diff_pos ? LEVEL_MAX : '0;
            end else begin
                lvl_reg <= '0;
            end
        end
        if (do_check && sat_hit) begin
            lvl_reg <= LEVEL_MAX;
        end
        if (state_reg == ST_DIVIDE && div_rsp.done) begin
            lvl_reg <= div_rsp.quotient;
        end
    end

    // ------------------------------------------------------- output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (do_finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_finish) begin
            m_level_reg    <= lvl_final;
            m_smoothed_reg <= filt_reg;
            m_changed_reg  <= changed_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_level         = m_level_reg;
    assign m_smoothed      = m_smoothed_reg;
    assign m_range_changed = m_changed_reg;

endmodule

`default_nettype wire
